// ===== hdl/tbs_pkg.sv =====
// Package for the token bucket shaper: field widths, event codes and
// sequencer state encoding. No dependencies.
package tbs_pkg;

  localparam int unsigned ID_W    = 32;
  localparam int unsigned TOKEN_W = 16;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned LEVEL_W = 5;
  localparam int unsigned ENTRY_W = ID_W + TOKEN_W;

  localparam logic [TOKEN_W-1:0] BUCKET_RESET = 16'd10;

  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_PACKET = 1'b1;

  typedef enum logic [EVENT_W-1:0] {
    EV_TOKEN_ADDED   = 3'd0,
    EV_TOKEN_DROPPED = 3'd1,
    EV_TOO_BIG       = 3'd2,
    EV_QUEUED        = 3'd3,
    EV_QUEUE_FULL    = 3'd4,
    EV_PASSED        = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

// ===== hdl/tbs_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tbs_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/token_bucket_shaper.sv =====
// Token bucket shaper: each input beat is registered on accept, then evaluated
// against the FIFO head entry read from the wait RAM into the output register.
// A new beat is accepted only in the idle state, so the next beat waits until the
// current one is evaluated; a stalled output register holds the evaluation.
// Synchronous active-high reset clears the bucket, pointers and count and sets
// bucket_size to 10; the wait RAM is not cleared and needs no clearing pass.
module token_bucket_shaper #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // config
  input  logic                         cfg_wen,
  input  logic [tbs_pkg::TOKEN_W-1:0]  cfg_wdata,   // bucket_size
  // input stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [47:0]                  s_tdata,     // packet_id[31:0], tokens_needed[47:32]
  input  logic                         s_tuser,     // req_type
  // output stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [55:0]                  m_tdata,     // released_id[31:0], token_level[47:32],
                                                    // queue_level[52:48], zero fill
  output logic [3:0]                   m_tuser      // event_code[2:0], released[3]
);
  import tbs_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  state_t state;

  logic [TOKEN_W-1:0] bucket_size;
  logic [TOKEN_W-1:0] token_total;
  logic [PW-1:0]      head_ptr;
  logic [PW-1:0]      tail_ptr;
  logic [CW-1:0]      wait_count;

  // accepted beat
  logic               item_kind;
  logic [ID_W-1:0]    item_id;
  logic [TOKEN_W-1:0] item_need;

  // output register
  logic               out_valid;
  event_t             out_ev;
  logic               out_rel;
  logic [ID_W-1:0]    out_rid;
  logic [TOKEN_W-1:0] out_tok;
  logic [LEVEL_W-1:0] out_q;

  logic [ENTRY_W-1:0] head_entry;
  logic [ID_W-1:0]    head_id;
  logic [TOKEN_W-1:0] head_need;

  logic               fire;
  logic               push;
  logic               pop;
  logic               q_empty;
  logic               q_full;
  logic [TOKEN_W-1:0] tok_inc;
  logic [TOKEN_W-1:0] token_total_next;
  event_t             ev_next;
  logic               rel_next;
  logic [ID_W-1:0]    rid_next;
  logic [CW-1:0]      wait_count_next;
  logic [CW+LEVEL_W-1:0] level_ext;

  tbs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (push),
    .waddr (tail_ptr),
    .wdata ({item_need, item_id}),
    .raddr (head_ptr),
    .rdata (head_entry)
  );

  assign head_id   = head_entry[ID_W-1:0];
  assign head_need = head_entry[ENTRY_W-1:ID_W];

  assign s_tready = (state == ST_IDLE);
  assign fire     = (state == ST_EXEC) && (!out_valid || m_tready);
  assign q_empty  = (wait_count == '0);
  assign q_full   = (wait_count >= CW'(QUEUE_DEPTH));
  assign tok_inc  = (token_total < bucket_size) ? token_total + 1'b1 : token_total;

  always_comb begin
    token_total_next = token_total;
    ev_next          = EV_TOKEN_ADDED;
    rel_next         = 1'b0;
    rid_next         = '0;
    push             = 1'b0;
    pop              = 1'b0;
    if (item_kind == REQ_TICK) begin
      ev_next          = (token_total < bucket_size) ? EV_TOKEN_ADDED : EV_TOKEN_DROPPED;
      token_total_next = tok_inc;
      if (!q_empty && tok_inc >= head_need) begin
        token_total_next = tok_inc - head_need;
        rel_next         = 1'b1;
        rid_next         = head_id;
        pop              = fire;
      end
    end else begin
      if (item_need > bucket_size) begin
        ev_next = EV_TOO_BIG;
      end else if (q_empty && token_total >= item_need) begin
        token_total_next = token_total - item_need;
        ev_next          = EV_PASSED;
        rel_next         = 1'b1;
        rid_next         = item_id;
      end else if (q_full) begin
        ev_next = EV_QUEUE_FULL;
      end else begin
        ev_next = EV_QUEUED;
        push    = fire;
      end
    end
  end

  always_comb begin
    wait_count_next = wait_count;
    if (push) begin
      wait_count_next = wait_count + 1'b1;
    end else if (pop) begin
      wait_count_next = wait_count - 1'b1;
    end
  end

  // count may be narrower or wider than the 5-bit level field
  assign level_ext = {{LEVEL_W{1'b0}}, wait_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      bucket_size <= BUCKET_RESET;
      token_total <= '0;
      head_ptr    <= '0;
      tail_ptr    <= '0;
      wait_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wen) begin
        bucket_size <= cfg_wdata;
      end
      // a new result replaces the one leaving in the same cycle
      if (fire) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (fire) begin
            state       <= ST_IDLE;
            token_total <= token_total_next;
            wait_count  <= wait_count_next;
            if (push) begin
              tail_ptr <= (tail_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_ptr + 1'b1;
            end
            if (pop) begin
              head_ptr <= (head_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : head_ptr + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item_kind <= s_tuser;
      item_id   <= s_tdata[ID_W-1:0];
      item_need <= s_tdata[ENTRY_W-1:ID_W];
    end
    if (fire) begin
      out_ev  <= ev_next;
      out_rel <= rel_next;
      out_rid <= rid_next;
      out_tok <= token_total_next;
      out_q   <= level_ext[LEVEL_W-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_q, out_tok, out_rid};
  assign m_tuser  = {out_rel, out_ev};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    wait_count <= CW'(QUEUE_DEPTH))
    else $error("wait count above queue depth");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (wait_count == '0 || wait_count == CW'(QUEUE_DEPTH)) |-> head_ptr == tail_ptr)
    else $error("head and tail pointers disagree with count");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && out_valid && !m_tready) |=> (state == ST_EXEC && $stable(token_total)))
    else $error("evaluation advanced while output stalled");

  a_pass_releases: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ev == EV_PASSED) |-> out_rel)
    else $error("passed packet not marked released");
`endif

endmodule

// ===== verif/token_bucket_shaper_test.sv =====
// Self-checking bench for token_bucket_shaper: random-gap stream stimulus, bucket size
// changes between phases, and a scoreboard that predicts every output beat.
// Depends on tbs_pkg and the token_bucket_shaper RTL.
`timescale 1ns / 1ps

module token_bucket_shaper_test;
  import tbs_pkg::*;

  localparam int unsigned QDEPTH = 16;
  localparam int PHASES = 9;
  localparam int unsigned RANDOM_SIZE = 32'hFFFF_FFFF;

  typedef struct {
    bit [ID_W-1:0]    id;
    bit [TOKEN_W-1:0] need;
  } held_pkt_t;

  typedef struct {
    event_t           code;
    bit               released;
    bit [ID_W-1:0]    rel_id;
    bit [TOKEN_W-1:0] level;
    bit [LEVEL_W-1:0] qlevel;
  } shaper_result_t;

  class bucket_scoreboard;
    bit [TOKEN_W-1:0] bucket_size;
    bit [TOKEN_W-1:0] tokens;
    held_pkt_t        waiting[$];
    shaper_result_t   pending_results[$];
    int               errors;

    function new();
      bucket_size = BUCKET_RESET;
      tokens = 0;
      errors = 0;
    endfunction

    function void set_bucket(bit [TOKEN_W-1:0] size);
      bucket_size = size;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // Advance the shaper state by one accepted input beat.
    function void note_beat(bit req, bit [ID_W-1:0] id, bit [TOKEN_W-1:0] need);
      shaper_result_t r;
      held_pkt_t pkt;
      r.released = 1'b0;
      r.rel_id = '0;
      if (req == REQ_TICK) begin
        if (tokens < bucket_size) begin
          tokens++;
          r.code = EV_TOKEN_ADDED;
        end else begin
          r.code = EV_TOKEN_DROPPED;
        end
        // head may still be blocked if it needs more than a shrunk bucket
        if (waiting.size() > 0 && tokens >= waiting[0].need) begin
          pkt = waiting.pop_front();
          tokens -= pkt.need;
          r.released = 1'b1;
          r.rel_id = pkt.id;
        end
      end else if (need > bucket_size) begin
        r.code = EV_TOO_BIG;
      end else if (waiting.size() == 0 && tokens >= need) begin
        tokens -= need;
        r.code = EV_PASSED;
        r.released = 1'b1;
        r.rel_id = id;
      end else if (waiting.size() >= QDEPTH) begin
        r.code = EV_QUEUE_FULL;
      end else begin
        pkt.id = id;
        pkt.need = need;
        waiting.push_back(pkt);
        r.code = EV_QUEUED;
      end
      r.level = tokens;
      r.qlevel = LEVEL_W'(waiting.size());
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [55:0] data, logic [3:0] user);
      shaper_result_t r;
      if (pending_results.size() == 0) begin
        $error("output beat with nothing expected: tdata %h tuser %h", data, user);
        errors++;
        return;
      end
      r = pending_results.pop_front();
      if (user[2:0] !== r.code) begin
        $error("event_code: expected %0d, got %0d", r.code, user[2:0]);
        errors++;
      end
      if (user[3] !== r.released) begin
        $error("released: expected %0d, got %0d", r.released, user[3]);
        errors++;
      end
      if (data[31:0] !== r.rel_id) begin
        $error("released_id: expected %h, got %h", r.rel_id, data[31:0]);
        errors++;
      end
      if (data[47:32] !== r.level) begin
        $error("token_level: expected %0d, got %0d", r.level, data[47:32]);
        errors++;
      end
      if (data[52:48] !== r.qlevel) begin
        $error("queue_level: expected %0d, got %0d", r.qlevel, data[52:48]);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_wen = 1'b0;
  logic [TOKEN_W-1:0]  cfg_wdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [47:0]         s_tdata = '0;     // packet_id[31:0], tokens_needed[47:32]
  logic                s_tuser = 1'b0;   // req_type
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [55:0]         m_tdata;          // released_id[31:0], token_level[47:32],
                                         // queue_level[52:48], zero fill
  logic [3:0]          m_tuser;          // event_code[2:0], released[3]

  bucket_scoreboard board;
  bit calm = 1'b0;
  int ready_hold = 0;

  // per-phase plan: bucket size, beat count, tick share, no-gap flag, blocked-head setup
  int unsigned plan_size[PHASES]  = '{20, 0, 1, 5, 40, 3, RANDOM_SIZE, 5, 65535};
  int          plan_count[PHASES] = '{300, 200, 200, 250, 300, 200, 250, 150, 150};
  int          plan_ticks[PHASES] = '{75, 50, 50, 55, 92, 50, 75, 50, 60};
  bit          plan_calm[PHASES]  = '{0, 0, 1, 0, 0, 0, 0, 1, 0};
  bit          plan_block[PHASES] = '{0, 0, 0, 0, 0, 0, 0, 1, 0};

  token_bucket_shaper #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic bit [TOKEN_W-1:0] pick_need();
    int unsigned r;
    int unsigned top;
    r = $urandom_range(0, 99);
    top = board.bucket_size + 1;
    if (top > 65535) top = 65535;
    if (r < 60) return TOKEN_W'($urandom_range(0, 3));
    if (r < 80) return TOKEN_W'($urandom_range(0, top));
    if (r < 90) return board.bucket_size;
    return TOKEN_W'($urandom());
  endfunction

  // receiver side back-pressure
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      m_tready <= 1'b0;
      ready_hold--;
    end else begin
      ready_hold = pick_gap();
      m_tready <= (ready_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
  end

  // valid stays high after the beat; the caller lowers it or presents the next beat
  task automatic send_beat(bit req, bit [ID_W-1:0] id, bit [TOKEN_W-1:0] need);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {need, id};
    s_tuser <= req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_beat(req, id, need);
  endtask

  task automatic send_tick();
    send_beat(REQ_TICK, $urandom(), TOKEN_W'($urandom()));
  endtask

  task automatic random_beat(int tick_pct);
    if ($urandom_range(0, 99) < tick_pct) send_tick();
    else send_beat(REQ_PACKET, $urandom(), pick_need());
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.outstanding() > 0) @(posedge clk);
  endtask

  task automatic write_bucket(bit [TOKEN_W-1:0] size);
    drain();
    repeat (4) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_wen <= 1'b0;
    board.set_bucket(size);
  endtask

  initial begin
    bit [TOKEN_W-1:0] size;
    board = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset bucket of 10, empty bucket
    send_tick();
    send_beat(REQ_PACKET, 32'h0000_0000, 16'd0);       // zero need, empty FIFO
    send_beat(REQ_PACKET, 32'hFFFF_FFFF, 16'd11);      // just over the bucket
    send_beat(REQ_PACKET, 32'hA5A5_A5A5, 16'hFFFF);
    send_beat(REQ_PACKET, 32'h5A5A_5A5A, 16'd1);
    send_beat(REQ_PACKET, 32'h1234_5678, 16'd3);       // queued, no tokens
    send_beat(REQ_PACKET, 32'h8765_4321, 16'd0);       // zero need behind a waiter
    repeat (3) send_tick();
    for (int i = 0; i < QDEPTH + 1; i++) send_beat(REQ_PACKET, $urandom(), 16'd10);

    for (int p = 0; p < PHASES; p++) begin
      if (plan_block[p]) begin
        // leave a head that needs more than the coming bucket size
        send_beat(REQ_PACKET, $urandom(), board.bucket_size);
        send_beat(REQ_PACKET, $urandom(), board.bucket_size);
      end
      if (plan_size[p] == RANDOM_SIZE) size = TOKEN_W'($urandom_range(40, 200));
      else size = TOKEN_W'(plan_size[p]);
      write_bucket(size);
      calm = plan_calm[p];
      for (int n = 0; n < plan_count[p]; n++) random_beat(plan_ticks[p]);
    end

    drain();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== token_bucket_shaper.f =====
hdl/tbs_pkg.sv
hdl/tbs_ram.sv
hdl/token_bucket_shaper.sv
verif/token_bucket_shaper_test.sv
